// ===== rtl/hbs_pkg.sv =====
package hbs_pkg;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Register indexes (byte address bit 2)
    localparam logic REG_TERRAIN_SIZE = 1'b0;
    localparam logic REG_INV_SCALE    = 1'b1;

    // Register reset values
    localparam logic [8:0]  TERRAIN_SIZE_RST = 9'd256;
    localparam logic [15:0] INV_SCALE_RST    = 16'd4096;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Width of the integer part of a map coordinate
    localparam int IPW = 20;

    typedef struct packed {
        logic               req_type;
        logic [7:0]         load_row;
        logic [7:0]         load_col;
        logic signed [15:0] load_height;
        logic [23:0]        world_x;
        logic [23:0]        world_z;
    } hbs_req_t;

    typedef struct packed {
        logic signed [15:0] height;
        logic               at_edge;
    } hbs_res_t;

    // One classified request: map coordinates are Q20.8 (product bits 39..12)
    typedef struct packed {
        logic               is_query;
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [15:0] height;
        logic [27:0]        px;
        logic [27:0]        pz;
    } hbs_entry_t;

    typedef struct packed {
        logic       valid;
        hbs_entry_t entry;
    } hbs_push_t;

    // floor(((b-a)*f + 128) / 256) + a
    function automatic logic signed [15:0] lerp8(input logic signed [15:0] a,
                                                 input logic signed [15:0] b,
                                                 input logic [7:0] f);
        logic signed [16:0] diff;
        logic signed [25:0] prod;
        logic signed [25:0] sum;
        logic signed [16:0] q;
        logic signed [16:0] r;
        diff = 17'(b) - 17'(a);
        prod = 26'(diff) * 26'(signed'({1'b0, f}));
        sum  = prod + 26'sd128;
        q    = 17'(sum >>> 8);
        r    = q + 17'(a);
        return r[15:0];
    endfunction

endpackage

// ===== rtl/hbs_front.sv =====
module hbs_front import hbs_pkg::*; #(
    parameter int MAP_SIDE = 256
) (
    input  logic        start,
    input  logic        busy,
    input  hbs_req_t    req,
    input  logic [15:0] inv_world_scale,
    output hbs_push_t   push
);

    logic        accept;
    logic        load_in_map;
    logic [39:0] px;
    logic [39:0] pz;

    assign accept = start && !busy;

    // loads outside the map are dropped here
    assign load_in_map = (int'(req.load_row) < MAP_SIDE) && (int'(req.load_col) < MAP_SIDE);

    // world position times reciprocal scale, Q20.20
    assign px = req.world_x * inv_world_scale;
    assign pz = req.world_z * inv_world_scale;

    always_comb
    begin
        push.valid         = accept && ((req.req_type == REQ_QUERY) || load_in_map);
        push.entry.is_query = (req.req_type == REQ_QUERY);
        push.entry.row     = req.load_row;
        push.entry.col     = req.load_col;
        push.entry.height  = req.load_height;
        push.entry.px      = px[39:12];
        push.entry.pz      = pz[39:12];
    end

endmodule

// ===== rtl/hbs_queue.sv =====
module hbs_queue import hbs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  hbs_push_t push,
    input  logic      pop,
    output hbs_push_t head,
    output logic      full
);

    hbs_entry_t     q_mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = q_mem[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ===== rtl/hbs_back.sv =====
module hbs_back import hbs_pkg::*; #(
    parameter int MAP_SIDE = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  hbs_push_t  head,
    input  logic [8:0] terrain_size,
    output logic       res_strobe,
    output hbs_res_t   res
);

    localparam int CW         = $clog2(MAP_SIDE);
    localparam int HW         = (CW > 1) ? CW - 1 : 1;
    localparam int AW         = 2 * HW;
    localparam int BANK_DEPTH = 1 << AW;

    // effective size minus one, and clamped integer parts
    logic [IPW-1:0] ts_ext;
    logic [IPW-1:0] effm1_ext;
    logic [CW-1:0]  effm1;
    logic [IPW-1:0] int_x;
    logic [IPW-1:0] int_z;
    logic [CW-1:0]  ix;
    logic [CW-1:0]  iz;
    logic           at_edge;
    logic [CW:0]    col_even;
    logic [CW:0]    col_odd;
    logic [CW:0]    row_even;
    logic [CW:0]    row_odd;

    // bank ports; bank index is {row parity, column parity}
    logic [3:0]         wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr [4];
    logic signed [15:0] rd_data_reg [4];

    // stage 1 side band
    logic       v1_reg;
    logic       edge1_reg;
    logic [7:0] fx1_reg;
    logic [7:0] fz1_reg;
    logic       px1_reg;
    logic       pz1_reg;

    // stage 2
    logic               v2_reg;
    logic               edge2_reg;
    logic [7:0]         fz2_reg;
    logic signed [15:0] bottom_reg;
    logic signed [15:0] top_reg;
    logic signed [15:0] bottom_next;
    logic signed [15:0] top_next;
    logic signed [15:0] h00;
    logic signed [15:0] h10;
    logic signed [15:0] h01;
    logic signed [15:0] h11;

    // stage 3
    logic     strobe_reg;
    hbs_res_t res_reg;
    hbs_res_t res_next;

    // clamp terrain size to 1..MAP_SIDE
    always_comb
    begin
        ts_ext = IPW'(terrain_size);
        if (ts_ext == '0)
        begin
            effm1_ext = '0;
        end
        else if (ts_ext > IPW'(MAP_SIDE))
        begin
            effm1_ext = IPW'(MAP_SIDE - 1);
        end
        else
        begin
            effm1_ext = ts_ext - 1'b1;
        end
    end
    assign effm1 = effm1_ext[CW-1:0];

    // saturate integer parts, flag edge
    assign int_x   = head.entry.px[27:8];
    assign int_z   = head.entry.pz[27:8];
    assign ix      = (int_x > effm1_ext) ? effm1 : int_x[CW-1:0];
    assign iz      = (int_z > effm1_ext) ? effm1 : int_z[CW-1:0];
    assign at_edge = (ix == effm1) || (iz == effm1);

    // column/row seen by the even and odd banks
    assign col_even = ix[0] ? (CW+1)'(ix) + 1'b1 : (CW+1)'(ix);
    assign col_odd  = ix[0] ? (CW+1)'(ix) : (CW+1)'(ix) + 1'b1;
    assign row_even = iz[0] ? (CW+1)'(iz) + 1'b1 : (CW+1)'(iz);
    assign row_odd  = iz[0] ? (CW+1)'(iz) : (CW+1)'(iz) + 1'b1;

    assign rd_addr[0] = {row_even[HW:1], col_even[HW:1]};
    assign rd_addr[1] = {row_even[HW:1], col_odd[HW:1]};
    assign rd_addr[2] = {row_odd[HW:1], col_even[HW:1]};
    assign rd_addr[3] = {row_odd[HW:1], col_odd[HW:1]};

    // load write decode
    assign wr_addr = {HW'(head.entry.row >> 1), HW'(head.entry.col >> 1)};
    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            wr_en[b] = head.valid && !head.entry.is_query
                       && ({head.entry.row[0], head.entry.col[0]} == 2'(b));
        end
    end

    // four banks, one write and one registered read each
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic signed [15:0] mem [BANK_DEPTH];
        always_ff @(posedge clk)
        begin
            if (wr_en[b])
            begin
                mem[wr_addr] <= head.entry.height;
            end
            rd_data_reg[b] <= mem[rd_addr[b]];
        end
    end

    // stage 1 side band
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= head.valid && head.entry.is_query;
        end
    end

    always_ff @(posedge clk)
    begin
        edge1_reg <= at_edge;
        fx1_reg   <= head.entry.px[7:0];
        fz1_reg   <= head.entry.pz[7:0];
        px1_reg   <= ix[0];
        pz1_reg   <= iz[0];
    end

    // stage 2: route corners, interpolate along x
    assign h00 = rd_data_reg[{pz1_reg, px1_reg}];
    assign h10 = rd_data_reg[{pz1_reg, ~px1_reg}];
    assign h01 = rd_data_reg[{~pz1_reg, px1_reg}];
    assign h11 = rd_data_reg[{~pz1_reg, ~px1_reg}];

    assign bottom_next = edge1_reg ? h00 : lerp8(h00, h10, fx1_reg);
    assign top_next    = lerp8(h01, h11, fx1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        edge2_reg  <= edge1_reg;
        fz2_reg    <= fz1_reg;
        bottom_reg <= bottom_next;
        top_reg    <= top_next;
    end

    // stage 3: interpolate along z
    always_comb
    begin
        res_next.height  = edge2_reg ? bottom_reg : lerp8(bottom_reg, top_reg, fz2_reg);
        res_next.at_edge = edge2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_strobe = strobe_reg;
    assign res        = res_reg;

endmodule

// ===== rtl/heightmap_bilinear_sampler.sv =====
// Path: a query passes the queue, bank read/stage 1, stage 2 and stage 3 registers.
// Throughput: one request per cycle while busy is low, in any mix of loads and queries;
//   four row/column parity banks hold the map so all four corners are read at once.
// Reset: rst_n clears control state, terrain_size to 256, inv_world_scale to 4096;
//   the height map holds nothing valid until loaded. Results are never stalled.
module heightmap_bilinear_sampler import hbs_pkg::*; #(
    parameter int MAP_SIDE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  hbs_req_t    req,
    output logic        res_strobe,
    output hbs_res_t    res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [8:0]  terrain_size_reg;
    logic [15:0] inv_world_scale_reg;
    logic        cfg_write;
    hbs_push_t   push;
    hbs_push_t   head;
    logic        q_full;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terrain_size_reg    <= TERRAIN_SIZE_RST;
            inv_world_scale_reg <= INV_SCALE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_TERRAIN_SIZE: terrain_size_reg    <= pwdata[8:0];
                REG_INV_SCALE:    inv_world_scale_reg <= pwdata[15:0];
                default:          terrain_size_reg    <= terrain_size_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TERRAIN_SIZE: prdata = {23'b0, terrain_size_reg};
            REG_INV_SCALE:    prdata = {16'b0, inv_world_scale_reg};
            default:          prdata = '0;
        endcase
    end

    assign busy = q_full;

    // front: take and classify requests, scale coordinates
    hbs_front #(
        .MAP_SIDE(MAP_SIDE)
    ) u_front (
        .start           (start),
        .busy            (busy),
        .req             (req),
        .inv_world_scale (inv_world_scale_reg),
        .push            (push)
    );

    // queue between front and back
    hbs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (head.valid),
        .head  (head),
        .full  (q_full)
    );

    // back: map store and interpolation pipeline
    hbs_back #(
        .MAP_SIDE(MAP_SIDE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .terrain_size (terrain_size_reg),
        .res_strobe   (res_strobe),
        .res          (res)
    );

`ifndef SYNTHESIS
    // back drains one entry per cycle, so the queue never fills
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("request queue filled up");

    // every taken query, and nothing else, yields a result strobe
    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe == ($past(rst_n && start && !busy && (req.req_type == REQ_QUERY), 4)
                       && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)))
        else $error("result strobe does not match taken queries");

    // a result strobe comes from a query
    a_edge_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |-> $past(req.req_type == REQ_QUERY, 4))
        else $error("result without a query");
`endif

endmodule
